[src/ipcidr_pkg.sv]
// ----------------------------------------------------------------------------
// ipcidr_pkg
// Shared types, constants and helper functions for the address range to
// prefix block splitter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipcidr_pkg;

  localparam int ADDR_BITS = 32;
  localparam int TAG_BITS  = 16;

  // Tag bits carried through; the tag port is 16 bits wide.
  localparam int TAG_KEEP = (TAG_BITS < 16) ? TAG_BITS : 16;

  // Width of a block exponent / prefix length (0..ADDR_BITS).
  localparam int KW = $clog2(ADDR_BITS + 1);

  // Depth of the queue between front and back.
  localparam int QDEPTH = 2;
  localparam int QPW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  // One nonempty range waiting to be walked. rem is the address count left.
  typedef struct packed {
    logic [ADDR_BITS-1:0] lo;
    logic [ADDR_BITS:0]   rem;
    logic [TAG_KEEP-1:0]  tag;
  } range_t;

  // Number of trailing zeros, ADDR_BITS for a zero value.
  function automatic logic [KW-1:0] trail_zeros(input logic [ADDR_BITS-1:0] v);
    logic [KW-1:0] n;
    n = KW'(ADDR_BITS);
    for (int i = ADDR_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        n = KW'(i);
      end
    end
    return n;
  endfunction

  // Position of the highest set bit, 0 for a zero value.
  function automatic logic [KW-1:0] top_bit(input logic [ADDR_BITS:0] v);
    logic [KW-1:0] n;
    n = '0;
    for (int i = 0; i <= ADDR_BITS; i++) begin
      if (v[i]) begin
        n = KW'(i);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

[src/ipcidr_front.sv]
// ----------------------------------------------------------------------------
// ipcidr_front
// Input stage: takes a range transaction, drops empty ranges and computes
// the address count before handing the range to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ipcidr_front
  import ipcidr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] in_range_low,
  input  wire logic [31:0] in_range_high,
  input  wire logic [15:0] in_entry_tag,
  output logic             q_push,
  output range_t           q_data,
  input  wire logic        q_full
);

  logic                 valid_r, valid_nxt;
  range_t               item_r, item_nxt;
  logic                 advance;
  logic [ADDR_BITS-1:0] lo_m, hi_m;
  logic                 keep;

  assign lo_m = in_range_low[ADDR_BITS-1:0];
  assign hi_m = in_range_high[ADDR_BITS-1:0];
  assign keep = (lo_m <= hi_m);

  // Holding register frees up when empty or when the queue takes it.
  assign advance = !valid_r || !q_full;
  assign full    = !advance;
  assign q_push  = valid_r && !q_full;
  assign q_data  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (advance) begin
      valid_nxt    = push && keep;
      item_nxt.lo  = lo_m;
      item_nxt.rem = {1'b0, hi_m} - {1'b0, lo_m} + (ADDR_BITS + 1)'(1);
      item_nxt.tag = in_entry_tag[TAG_KEEP-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

[src/ipcidr_queue.sv]
// ----------------------------------------------------------------------------
// ipcidr_queue
// Short FIFO of ranges between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module ipcidr_queue
  import ipcidr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   wr_en,
  input  wire range_t wr_data,
  output logic        q_full,
  input  wire logic   rd_en,
  output range_t      rd_data,
  output logic        q_empty
);

  range_t           mem_r [QDEPTH];
  logic [QPW-1:0]   wptr_r, rptr_r;
  logic [QCW-1:0]   cnt_r;
  logic             do_wr, do_rd;

  assign q_full  = (cnt_r == QCW'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == QPW'(QDEPTH - 1)) ? '0 : wptr_r + QPW'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == QPW'(QDEPTH - 1)) ? '0 : rptr_r + QPW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + QCW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - QCW'(1);
      end
    end
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

[src/ipcidr_back.sv]
// ----------------------------------------------------------------------------
// ipcidr_back
// Block walker: emits one aligned prefix block per cycle into an output
// register, while that register is free or being popped, until the range is covered.
// ----------------------------------------------------------------------------
`default_nettype none

module ipcidr_back
  import ipcidr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire range_t q_data,
  input  wire logic   q_empty,
  output logic        q_pop,
  output logic        empty,
  input  wire logic   pop,
  output logic [31:0] out_block_base,
  output logic [5:0]  out_prefix_len,
  output logic [15:0] out_tag_out,
  output logic        out_last_block
);

  logic                 busy_r;
  logic [ADDR_BITS-1:0] lo_r;
  logic [ADDR_BITS:0]   rem_r;
  logic [TAG_KEEP-1:0]  tag_r;

  logic                 ovalid_r;
  logic [ADDR_BITS-1:0] obase_r;
  logic [KW-1:0]        olen_r;
  logic [TAG_KEEP-1:0]  otag_r;
  logic                 olast_r;

  logic [KW-1:0]        k_tz, k_fit, k;
  logic [ADDR_BITS:0]   size;
  logic                 last;
  logic                 step;

  // Block exponent: limited by alignment of lo and by the count left.
  assign k_tz  = trail_zeros(lo_r);
  assign k_fit = top_bit(rem_r);
  assign k     = (k_tz < k_fit) ? k_tz : k_fit;
  assign size  = (ADDR_BITS + 1)'(1) << k;
  assign last  = (rem_r == size);

  assign step  = busy_r && (!ovalid_r || pop);
  assign q_pop = !busy_r && !q_empty;

  assign empty          = !ovalid_r;
  assign out_block_base = 32'(obase_r);
  assign out_prefix_len = 6'(olen_r);
  assign out_tag_out    = 16'(otag_r);
  assign out_last_block = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
      end else if (step && last) begin
        busy_r <= 1'b0;
      end
      if (step) begin
        ovalid_r <= 1'b1;
      end else if (pop) begin
        ovalid_r <= 1'b0;
      end
    end
    if (q_pop) begin
      lo_r  <= q_data.lo;
      rem_r <= q_data.rem;
      tag_r <= q_data.tag;
    end else if (step) begin
      lo_r  <= lo_r + size[ADDR_BITS-1:0];
      rem_r <= rem_r - size;
    end
    if (step) begin
      obase_r <= lo_r;
      olen_r  <= KW'(ADDR_BITS) - k;
      otag_r  <= tag_r;
      olast_r <= last;
    end
  end

endmodule

`default_nettype wire

[src/ip_range_to_cidr_blocks_core.sv]
// ----------------------------------------------------------------------------
// ip_range_to_cidr_blocks_core
// Splits an inclusive address range into the minimal ordered list of aligned
// prefix blocks, one result transaction per block.
// ----------------------------------------------------------------------------
// Each input transaction carries a range [low, high] and a tag; the core emits
// the covering prefix blocks in ascending order, the final one flagged with
// last_block. Ranges with low above high produce nothing. The walker emits one
// block per clock while its output register is free or being popped; a range
// needing N blocks (N up to 62) holds it for those blocks and a load of the next
// range from the internal queue; that single walker and its output register set
// the throughput. The input side keeps taking ranges while the walker is busy
// until a two-entry queue and the input holding register are full. A result
// waiting in the output register for pop holds the walker; the input side stalls
// only once the queue and the holding register have filled up behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_range_to_cidr_blocks_core
  import ipcidr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        push,
  output logic             full,
  input  wire logic [31:0] in_range_low,
  input  wire logic [31:0] in_range_high,
  input  wire logic [15:0] in_entry_tag,
  // result channel
  output logic             empty,
  input  wire logic        pop,
  output logic [31:0]      out_block_base,
  output logic [5:0]       out_prefix_len,
  output logic [15:0]      out_tag_out,
  output logic             out_last_block
);

  // front -> queue
  logic   fq_push;
  range_t fq_data;
  logic   fq_full;
  // queue -> back
  range_t qb_data;
  logic   qb_empty;
  logic   qb_pop;

  // Front: classifies and precomputes the address count.
  ipcidr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .in_entry_tag  (in_entry_tag),
    .q_push        (fq_push),
    .q_data        (fq_data),
    .q_full        (fq_full)
  );

  // Decoupling queue.
  ipcidr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data (fq_data),
    .q_full  (fq_full),
    .rd_en   (qb_pop),
    .rd_data (qb_data),
    .q_empty (qb_empty)
  );

  // Back: walks the range one block per cycle while its output register is free or popped.
  ipcidr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_data         (qb_data),
    .q_empty        (qb_empty),
    .q_pop          (qb_pop),
    .empty          (empty),
    .pop            (pop),
    .out_block_base (out_block_base),
    .out_prefix_len (out_prefix_len),
    .out_tag_out    (out_tag_out),
    .out_last_block (out_last_block)
  );

endmodule

`default_nettype wire

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb - range to prefix block splitter testbench
// Drives address ranges into ip_range_to_cidr_blocks_core through its push
// queue and pops the emitted prefix blocks with a random stall pattern. A
// behavioral splitter in the bench predicts every block, and each popped
// transaction is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipcidr_pkg::*;

  localparam logic [31:0] TOP_ADDR      = 32'hFFFF_FFFF;
  localparam int          MAX_BLOCKS    = 62;       // worst case split of a 32-bit range
  localparam int          RANDOM_RANGES = 220;      // nonempty ranges in the random test
  localparam int          MAX_STALL     = 12;       // longest receiver stall, cycles
  localparam int          TAIL_CYCLES   = 2 * MAX_BLOCKS + 8;
  // Worst case: every range split 62 ways, every block behind a full stall.
  localparam int          CYCLE_LIMIT   = 1_000_000;

  // Receiver behavior, switched at random intervals.
  typedef enum logic [1:0] {
    RX_STREAM,       // pop every cycle
    RX_COIN,         // pop on a coin flip
    RX_LONG_STALLS   // mostly pop, with occasional long stalls
  } rx_mode_e;

  // One predicted prefix block.
  typedef struct packed {
    logic [31:0] base;
    logic [5:0]  plen;
    logic [15:0] tag;
    logic        is_last;
  } cidr_block_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [31:0] in_range_low   = '0;
  logic [31:0] in_range_high  = '0;
  logic [15:0] in_entry_tag   = '0;
  logic        empty;
  logic        pop            = 1'b0;
  logic [31:0] out_block_base;
  logic [5:0]  out_prefix_len;
  logic [15:0] out_tag_out;
  logic        out_last_block;

  cidr_block_t pending_blocks[$];   // predicted blocks not yet popped
  cidr_block_t want;
  int          errors     = 0;
  int          cycles     = 0;
  int          burst_left = 1;
  bit          gaps_on    = 1'b1;
  rx_mode_e    rx_mode    = RX_STREAM;
  int          rx_timer   = 0;
  int          stall_left = 0;

  ip_range_to_cidr_blocks_core uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_range_low   (in_range_low),
    .in_range_high  (in_range_high),
    .in_entry_tag   (in_entry_tag),
    .empty          (empty),
    .pop            (pop),
    .out_block_base (out_block_base),
    .out_prefix_len (out_prefix_len),
    .out_tag_out    (out_tag_out),
    .out_last_block (out_last_block)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: walk the range, taking at each step the largest block that is
  // aligned at the current start and still ends at or below hi. 33-bit math
  // so the block that ends at the top of the space does not wrap.
  // --------------------------------------------------------------------------
  task automatic split_range(input logic [31:0] lo, input logic [31:0] hi,
                             input logic [15:0] tag);
    logic [32:0] cur;
    logic [32:0] blk_end;
    int          k;
    cidr_block_t blk;
    if (lo > hi) return;    // empty range: nothing comes out
    cur = {1'b0, lo};
    for (int n = 0; n < MAX_BLOCKS; n++) begin
      // alignment limit: trailing zeros of the start (32 for address zero)
      k = 0;
      while (k < ADDR_BITS && !cur[k]) k++;
      blk_end = cur + ((33'd1 << k) - 33'd1);
      // shrink until the block fits under hi
      while (k > 0 && blk_end > {1'b0, hi}) begin
        k--;
        blk_end = cur + ((33'd1 << k) - 33'd1);
      end
      blk.base    = cur[31:0];
      blk.plen    = 6'(ADDR_BITS - k);
      blk.tag     = tag;
      blk.is_last = (blk_end == {1'b0, hi}) || (blk_end == {1'b0, TOP_ADDR});
      pending_blocks.push_back(blk);
      if (blk.is_last) break;
      cur = blk_end + 33'd1;
    end
  endtask

  // --------------------------------------------------------------------------
  // Sender. Inputs change on the falling edge; a transaction completes at the
  // rising edge where push is high and full is low.
  // --------------------------------------------------------------------------
  task automatic idle_sender(input int n);
    repeat (n) begin
      @(negedge clk);
      push = 1'b0;
    end
  endtask

  task automatic send_range(input logic [31:0] lo, input logic [31:0] hi,
                            input logic [15:0] tag);
    @(negedge clk);
    push          = 1'b1;
    in_range_low  = lo;
    in_range_high = hi;
    in_entry_tag  = tag;
    do begin
      @(posedge clk);
    end while (full);
    split_range(lo, hi, tag);
    // bursts of random length, random gaps between them
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if (gaps_on) idle_sender($urandom_range(1, 8));
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Hold off until every predicted block has been popped.
  task automatic wait_drained();
    idle_sender(1);
    while (pending_blocks.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: stall pattern of its own, changed at random intervals.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_timer == 0) begin
      rx_mode  = rx_mode_e'($urandom_range(0, 2));
      rx_timer = $urandom_range(50, 300);
    end else begin
      rx_timer--;
    end
    if (stall_left > 0) begin
      pop = 1'b0;
      stall_left--;
    end else begin
      case (rx_mode)
        RX_STREAM: begin
          pop = 1'b1;
        end
        RX_COIN: begin
          pop = 1'($urandom_range(0, 1));
        end
        default: begin
          pop = 1'b1;
          if ($urandom_range(0, 9) == 0) stall_left = $urandom_range(1, MAX_STALL);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Checker: every popped transaction against the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && pop && !empty) begin
      if (pending_blocks.size() == 0) begin
        $error("unexpected block: base %h prefix %0d tag %h last %b",
               out_block_base, out_prefix_len, out_tag_out, out_last_block);
        errors++;
      end else begin
        want = pending_blocks.pop_front();
        if (out_block_base !== want.base) begin
          $error("block_base: expected %h, got %h", want.base, out_block_base);
          errors++;
        end
        if (out_prefix_len !== want.plen) begin
          $error("prefix_len: expected %0d, got %0d", want.plen, out_prefix_len);
          errors++;
        end
        if (out_tag_out !== want.tag) begin
          $error("tag_out: expected %h, got %h", want.tag, out_tag_out);
          errors++;
        end
        if (out_last_block !== want.is_last) begin
          $error("last_block: expected %b, got %b", want.is_last, out_last_block);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Whole space, single addresses at both ends, top of space, plain prefixes.
  task automatic test_space_edges();
    send_range(32'h0000_0000, TOP_ADDR,     16'h0000);  // one /0 block
    send_range(32'h0000_0000, 32'h0000_0000, 16'hFFFF);
    send_range(TOP_ADDR,      TOP_ADDR,     16'hAAAA);
    send_range(32'hFFFF_FFFE, TOP_ADDR,     16'h5555);
    send_range(32'h8000_0000, TOP_ADDR,     16'h1234);
    send_range(32'h1234_5678, 32'h1234_5678, 16'h8001);
    send_range(32'h0A00_0000, 32'h0AFF_FFFF, 16'h7FFE);
    send_range(32'h0000_0000, 32'hFFFF_FFFE, 16'h00FF);
    wait_drained();
  endtask

  // low above high gives nothing; a normal range after must come out alone.
  task automatic test_empty_ranges();
    send_range(32'h0000_0005, 32'h0000_0004, 16'h0001);
    send_range(TOP_ADDR,      32'h0000_0000, 16'hFFFF);
    send_range(32'h8000_0000, 32'h7FFF_FFFF, 16'hAAAA);
    send_range(32'h0000_0001, 32'h0000_0001, 16'h5555);
    wait_drained();
  endtask

  // Longest splits, including the walk that must stop at the all-ones address.
  task automatic test_longest_splits();
    send_range(32'h0000_0001, 32'hFFFF_FFFE, 16'hC3C3);  // 62 blocks
    send_range(32'h0000_0001, TOP_ADDR,     16'h3C3C);
    send_range(32'h5555_5555, 32'hAAAA_AAAA, 16'h0F0F);
    send_range(32'hAAAA_AAAB, TOP_ADDR,     16'hF0F0);
    wait_drained();
  endtask

  // Back-to-back ranges to fill the input queue, then a full pause.
  task automatic test_drain_pause();
    gaps_on = 1'b0;
    repeat (6) begin
      send_range($urandom_range(0, 1000), $urandom_range(1000, 40000),
                 16'($urandom));
    end
    wait_drained();
    send_range(32'h0000_0010, 32'h0000_002F, 16'hBEEF);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // Random mix; empty ranges are sent but not counted.
  task automatic test_random_ranges();
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mask;
    logic [32:0] sum;
    int          sel;
    int          k;
    int          sent  = 0;
    int          items = 0;
    while (sent < RANDOM_RANGES) begin
      if (items % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      items++;
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        // short span anywhere, clamped at the top
        lo  = $urandom;
        sum = {1'b0, lo} + 33'($urandom_range(0, 300));
        hi  = sum[32] ? TOP_ADDR : sum[31:0];
      end else if (sel < 60) begin
        // exactly one aligned prefix
        k    = $urandom_range(0, 32);
        mask = 32'((33'd1 << k) - 33'd1);
        lo   = $urandom & ~mask;
        hi   = lo | mask;
      end else if (sel < 75) begin
        // wide range, long split
        lo = $urandom;
        hi = $urandom;
        if (lo > hi) {lo, hi} = {hi, lo};
      end else if (sel < 85) begin
        // near the top of the space
        lo = TOP_ADDR - 32'($urandom_range(0, 5000));
        hi = ($urandom_range(0, 1) == 1) ? TOP_ADDR : lo + 32'($urandom_range(0, ~lo));
      end else if (sel < 92) begin
        // near the bottom
        lo = $urandom_range(0, 100);
        hi = $urandom_range(lo, 100000);
      end else begin
        // empty range
        lo = $urandom;
        hi = $urandom;
        if (lo < hi) {lo, hi} = {hi, lo};
        if (lo == hi) begin
          if (lo == TOP_ADDR) hi = lo - 32'd1;
          else lo = hi + 32'd1;
        end
      end
      if (lo <= hi) sent++;
      send_range(lo, hi, 16'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_space_edges();
    test_empty_ranges();
    test_longest_splits();
    test_drain_pause();
    test_random_ranges();

    // drain, then give the walker time to show any stray block
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
src/ipcidr_pkg.sv
src/ipcidr_front.sv
src/ipcidr_queue.sv
src/ipcidr_back.sv
src/ip_range_to_cidr_blocks_core.sv
test/tb.sv
